// ===== design/bsde_pkg.sv =====
// bsde_pkg: types and constants shared by the backup stream data extractor.
// Depends on nothing; every other design file except bsde_if.sv refers to it by scoped names.
package bsde_pkg;

	// record header length in bytes
	localparam int unsigned HEADER_BYTES = 20;
	localparam int unsigned HDR_IDX_W    = $clog2(HEADER_BYTES);

	// reset value of the selected data stream id
	localparam logic [31:0] DATA_ID_RESET = 32'd1;

	// parse phase; code 3 is unused and behaves as header phase
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_NAME   = 2'd1,
		PH_BODY   = 2'd2
	} phase_t;

	// one input item as held in the input register
	typedef struct packed {
		logic [7:0] data_in;
		logic       block_end;
	} item_t;

	// one result item
	typedef struct packed {
		logic [7:0] data_out;
		logic       data_valid;
		logic       block_end_out;
	} result_t;

endpackage

// ===== design/bsde_if.sv =====
// Handshake channel interfaces of the backup stream data extractor.
// Depends on nothing; one interface per channel kind.

// raw byte stream channel
interface bsde_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_in;
	logic       block_end;

	modport source (output valid, output data_in, output block_end, input ready);
	modport sink (input valid, input data_in, input block_end, output ready);
endinterface

// result channel
interface bsde_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;
	logic       data_valid;
	logic       block_end_out;

	modport source (output valid, output data_out, output data_valid,
		output block_end_out, input ready);
	modport sink (input valid, input data_out, input data_valid,
		input block_end_out, output ready);
endinterface

// configuration write channel
interface bsde_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_stream_id;

	modport source (output valid, output data_stream_id, input ready);
	modport sink (input valid, input data_stream_id, output ready);
endinterface

// ===== design/bsde_in_stage.sv =====
// bsde_in_stage: input register of the extractor, one item deep.
// Depends on bsde_pkg (item_t).
module bsde_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bsde_pkg::item_t      in_item,
	input  logic                 advance,
	output logic                 valid_s1,
	output bsde_pkg::item_t      item_s1
);

	// register empties or moves on when the next stage advances
	assign in_ready = !valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== design/bsde_parser.sv =====
// bsde_parser: record parser state and per-byte result logic.
// Depends on bsde_pkg (phase_t, item_t, result_t, header constants).
module bsde_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_data,
	input  logic                 fire,
	input  bsde_pkg::item_t      item,
	output bsde_pkg::result_t    result
);

	localparam int unsigned IW = bsde_pkg::HDR_IDX_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(bsde_pkg::HEADER_BYTES - 1);

	bsde_pkg::phase_t phase_q, phase_n;
	logic [IW-1:0]    hdr_idx_q, hdr_idx_n, idx_c;
	logic [31:0]      id_q, id_n, id_base;
	logic [63:0]      body_q, body_n, body_base;
	logic [31:0]      name_q, name_n, name_base;
	logic [63:0]      rem_q, rem_n, rem_dec;
	logic             sel_q, sel_n;
	logic [31:0]      data_id_q;
	logic             rem_last;
	logic             hdr_last;
	logic             valid_c;

	// selected stream id register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_id_q <= bsde_pkg::DATA_ID_RESET;
		end else if (cfg_we) begin
			data_id_q <= cfg_data;
		end
	end

	// header byte position, clamped to the last byte
	assign idx_c    = (hdr_idx_q > LAST_IDX) ? LAST_IDX : hdr_idx_q;
	assign hdr_last = (idx_c == LAST_IDX);

	// header field capture; first byte starts from clear fields
	assign id_base   = (idx_c == '0) ? 32'd0 : id_q;
	assign body_base = (idx_c == '0) ? 64'd0 : body_q;
	assign name_base = (idx_c == '0) ? 32'd0 : name_q;

	always_comb begin
		id_n   = id_base;
		body_n = body_base;
		name_n = name_base;
		if (idx_c < IW'(4)) begin
			id_n = id_base | ({24'd0, item.data_in} << {idx_c[1:0], 3'b000});
		end else if (idx_c >= IW'(8) && idx_c < IW'(16)) begin
			body_n = body_base | ({56'd0, item.data_in} << {idx_c[2:0], 3'b000});
		end else if (idx_c >= IW'(16)) begin
			name_n = name_base | ({24'd0, item.data_in} << {idx_c[1:0], 3'b000});
		end
	end

	// name/body countdown: saturating decrement, ends when at most one left
	assign rem_dec  = (rem_q != 64'd0) ? rem_q - 64'd1 : 64'd0;
	assign rem_last = (rem_q[63:1] == 63'd0);

	// next state
	always_comb begin
		phase_n   = phase_q;
		hdr_idx_n = hdr_idx_q;
		rem_n     = rem_q;
		sel_n     = sel_q;
		unique case (phase_q)
			bsde_pkg::PH_NAME: begin
				rem_n = rem_dec;
				if (rem_last) begin
					if (body_q != 64'd0) begin
						phase_n = bsde_pkg::PH_BODY;
						rem_n   = body_q;
					end else begin
						phase_n = bsde_pkg::PH_HEADER;
						rem_n   = 64'd0;
					end
				end
			end
			bsde_pkg::PH_BODY: begin
				rem_n = rem_dec;
				if (rem_last) begin
					phase_n = bsde_pkg::PH_HEADER;
				end
			end
			default: begin
				phase_n = bsde_pkg::PH_HEADER;
				if (hdr_last) begin
					hdr_idx_n = '0;
					sel_n     = (id_n == data_id_q);
					if (name_n != 32'd0) begin
						phase_n = bsde_pkg::PH_NAME;
						rem_n   = {32'd0, name_n};
					end else if (body_n != 64'd0) begin
						phase_n = bsde_pkg::PH_BODY;
						rem_n   = body_n;
					end else begin
						rem_n = 64'd0;
					end
				end else begin
					hdr_idx_n = idx_c + IW'(1);
				end
			end
		endcase
	end

	// result for the current item
	always_comb begin
		valid_c              = (phase_q == bsde_pkg::PH_BODY) && sel_q;
		result.data_valid    = valid_c;
		result.data_out      = valid_c ? item.data_in : 8'd0;
		result.block_end_out = item.block_end;
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= bsde_pkg::PH_HEADER;
			hdr_idx_q <= '0;
			id_q      <= 32'd0;
			body_q    <= 64'd0;
			name_q    <= 32'd0;
			rem_q     <= 64'd0;
			sel_q     <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			hdr_idx_q <= hdr_idx_n;
			rem_q   <= rem_n;
			sel_q   <= sel_n;
			if (phase_q != bsde_pkg::PH_NAME && phase_q != bsde_pkg::PH_BODY) begin
				id_q   <= id_n;
				body_q <= body_n;
				name_q <= name_n;
			end
		end
	end

	// name and body phases always have bytes left to count
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == bsde_pkg::PH_NAME || phase_q == bsde_pkg::PH_BODY) |-> rem_q != 64'd0)
		else $error("name/body phase with zero count");

	// header index stays inside the header
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_idx_q <= LAST_IDX)
		else $error("header index out of range");

	// completing a header restarts the index
	a_hdr_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == bsde_pkg::PH_HEADER && hdr_last |=> hdr_idx_q == '0)
		else $error("header index not restarted");

	// header index only moves in header phase
	a_idx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == bsde_pkg::PH_NAME || phase_q == bsde_pkg::PH_BODY) |=> $stable(hdr_idx_q))
		else $error("header index moved outside header");

endmodule

// ===== design/bsde_out_stage.sv =====
// bsde_out_stage: result register of the extractor.
// Depends on bsde_pkg (result_t).
module bsde_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  bsde_pkg::result_t    result,
	input  logic                 out_ready,
	output logic                 advance,
	output logic                 valid_s2,
	output bsde_pkg::result_t    result_s2
);

	// register may take a new result when empty or being drained
	assign advance = !valid_s2 || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= load;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (advance && load) begin
			result_s2 <= result;
		end
	end

endmodule

// ===== design/backup_stream_data_extractor.sv =====
// backup_stream_data_extractor: top level, input register, parser, result register.
// Depends on bsde_pkg, bsde_if.sv, bsde_in_stage, bsde_parser, bsde_out_stage.
//
//  channel  | dir | payload                                  | accepted when
//  ---------+-----+------------------------------------------+---------------------
//  src_ch   | in  | data_in[7:0], block_end                  | valid && ready
//  res_ch   | out | data_out[7:0], data_valid, block_end_out | valid && ready
//  cfg_ch   | in  | data_stream_id[31:0]                     | valid (ready tied 1)
//
// One byte per clock sustained while res_ch.ready stays high; results come from the result register.
// The rate is set by the combinational parser step between the two registers.
// arst_n clears the parser to header phase and data_stream_id to 1.
// A stalled result holds in the result register; the input register takes an item
// only while empty, and once it holds one src_ch.ready drops until the result is taken.
module backup_stream_data_extractor (
	input  logic                 clk,
	input  logic                 arst_n,
	bsde_byte_if.sink            src_ch,
	bsde_result_if.source        res_ch,
	bsde_cfg_if.sink             cfg_ch
);

	bsde_pkg::item_t   src_item;
	bsde_pkg::item_t   item_s1;
	bsde_pkg::result_t result_c;
	bsde_pkg::result_t result_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;
	logic              fire;

	assign src_item.data_in   = src_ch.data_in;
	assign src_item.block_end = src_ch.block_end;

	// configuration is always taken
	assign cfg_ch.ready = 1'b1;

	// input register
	bsde_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (src_ch.valid),
		.in_ready (src_ch.ready),
		.in_item  (src_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// parser works on the held item when it moves to the result register
	assign fire = valid_s1 && advance;

	bsde_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_ch.valid),
		.cfg_data (cfg_ch.data_stream_id),
		.fire     (fire),
		.item     (item_s1),
		.result   (result_c)
	);

	// result register
	bsde_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.result    (result_c),
		.out_ready (res_ch.ready),
		.advance   (advance),
		.valid_s2  (valid_s2),
		.result_s2 (result_s2)
	);

	assign res_ch.valid         = valid_s2;
	assign res_ch.data_out      = result_s2.data_out;
	assign res_ch.data_valid    = result_s2.data_valid;
	assign res_ch.block_end_out = result_s2.block_end_out;

	// a held item is never dropped while the result side stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input item lost during stall");

	// a stalled result stays valid
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_ch.ready |=> valid_s2 && $stable(result_s2))
		else $error("result changed during stall");

	// a fired item always produces a result next cycle
	a_fire_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("result missing after parse");

endmodule
